FILE: hdl/ubx_pkg.sv
// Shared types and constants of the UBX frame receiver.
`default_nettype none
package ubx_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_CLASS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ID = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LENGTH = 2'd2;

  localparam logic [7:0] CLASS_RST = 8'h01;
  localparam logic [7:0] ID_RST = 8'h07;
  localparam logic [15:0] LENGTH_RST = 16'h0054;

  localparam logic [7:0] SYNC_FIRST = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD = 2'd2;

  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LENLO   = 9'b000010000,
    PH_LENHI   = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CKA     = 9'b010000000,
    PH_CKB     = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0]  exp_class;
    logic [7:0]  exp_id;
    logic [15:0] exp_length;
  } cfg_t;

  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic [15:0] byte_index;
    logic [7:0]  payload_byte;
  } result_req_t;

endpackage
`default_nettype wire

FILE: hdl/ubx_cfg_regs.sv
// Configuration registers of the UBX frame receiver.
`default_nettype none
module ubx_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ubx_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [ubx_pkg::CfgDataW-1:0]     cfg_data,
  output ubx_pkg::cfg_t                         cfg
);

  ubx_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exp_class <= ubx_pkg::CLASS_RST;
      cfg_r.exp_id <= ubx_pkg::ID_RST;
      cfg_r.exp_length <= ubx_pkg::LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ubx_pkg::CFG_CLASS: begin
          cfg_r.exp_class <= cfg_data[7:0];
        end
        ubx_pkg::CFG_ID: begin
          cfg_r.exp_id <= cfg_data[7:0];
        end
        ubx_pkg::CFG_LENGTH: begin
          cfg_r.exp_length <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: hdl/ubx_parser.sv
// Frame parser: sync hunt, header check, payload indexing and Fletcher checksum.
`default_nettype none
module ubx_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    rx_byte,
  input  wire ubx_pkg::cfg_t cfg,
  output ubx_pkg::result_req_t res
);

  ubx_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  ck_a_r, ck_a_nxt;
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] count_inc;
  ubx_pkg::phase_t miss_phase;

  assign add_a = sum_a_r + rx_byte;
  assign add_b = sum_b_r + add_a;
  assign count_inc = count_r + 16'd1;
  assign miss_phase = (rx_byte == ubx_pkg::SYNC_FIRST) ? ubx_pkg::PH_SYNC2 : ubx_pkg::PH_HUNT;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    len_lo_nxt = len_lo_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    ck_a_nxt = ck_a_r;
    res = '0;
    case (phase_r)
      ubx_pkg::PH_SYNC2: begin
        if (rx_byte == ubx_pkg::SYNC_SECOND) begin
          sum_a_nxt = '0;
          sum_b_nxt = '0;
          count_nxt = '0;
          phase_nxt = ubx_pkg::PH_CLASS;
        end else if (rx_byte != ubx_pkg::SYNC_FIRST) begin
          phase_nxt = ubx_pkg::PH_HUNT;
        end
      end
      ubx_pkg::PH_CLASS: begin
        if (rx_byte == cfg.exp_class) begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = ubx_pkg::PH_ID;
        end else begin
          phase_nxt = miss_phase;
        end
      end
      ubx_pkg::PH_ID: begin
        if (rx_byte == cfg.exp_id) begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = ubx_pkg::PH_LENLO;
        end else begin
          phase_nxt = miss_phase;
        end
      end
      ubx_pkg::PH_LENLO: begin
        if (rx_byte == cfg.exp_length[7:0]) begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          len_lo_nxt = rx_byte;
          phase_nxt = ubx_pkg::PH_LENHI;
        end else begin
          phase_nxt = miss_phase;
        end
      end
      ubx_pkg::PH_LENHI: begin
        if ({rx_byte, len_lo_r} == cfg.exp_length) begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          count_nxt = '0;
          phase_nxt = (cfg.exp_length == 16'd0) ? ubx_pkg::PH_CKA : ubx_pkg::PH_PAYLOAD;
        end else begin
          phase_nxt = miss_phase;
        end
      end
      ubx_pkg::PH_PAYLOAD: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        res.vld = 1'b1;
        res.kind = ubx_pkg::KIND_PAYLOAD;
        res.byte_index = count_r;
        res.payload_byte = rx_byte;
        count_nxt = count_inc;
        if (count_inc >= cfg.exp_length || count_inc == 16'd0) begin
          phase_nxt = ubx_pkg::PH_CKA;
        end
      end
      ubx_pkg::PH_CKA: begin
        ck_a_nxt = rx_byte;
        phase_nxt = ubx_pkg::PH_CKB;
      end
      ubx_pkg::PH_CKB: begin
        phase_nxt = ubx_pkg::PH_HUNT;
        res.vld = 1'b1;
        res.kind = (ck_a_r == sum_a_r && rx_byte == sum_b_r) ?
                   ubx_pkg::KIND_GOOD : ubx_pkg::KIND_BAD;
      end
      default: begin
        phase_nxt = miss_phase;
      end
    endcase
    if (!accept) begin
      res.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ubx_pkg::PH_HUNT;
      count_r <= '0;
      len_lo_r <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      ck_a_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      len_lo_r <= len_lo_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      ck_a_r <= ck_a_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ubx_out_buf.sv
// Two-entry output buffer: result register plus skid entry.
`default_nettype none
module ubx_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ubx_pkg::result_req_t push,
  output logic                      full,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_kind,
  output logic [15:0]               out_byte_index,
  output logic [7:0]                out_payload_byte
);

  logic main_vld_r;
  logic skid_vld_r;
  ubx_pkg::result_req_t main_r;
  ubx_pkg::result_req_t skid_r;
  logic drain;
  logic main_free;

  assign drain = main_vld_r && !out_stall;
  assign main_free = !main_vld_r || drain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (drain) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push.vld) begin
      if (main_free) begin
        main_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (drain) begin
      main_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (drain) begin
        main_r <= skid_r;
      end
    end else if (push.vld) begin
      if (main_free) begin
        main_r <= push;
      end else begin
        skid_r <= push;
      end
    end
  end

  assign full = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_kind = main_r.kind;
  assign out_byte_index = main_r.byte_index;
  assign out_payload_byte = main_r.payload_byte;

endmodule
`default_nettype wire

FILE: hdl/ubx_frame_receiver_top.sv
// Top level of the UBX frame receiver.
`default_nettype none
// Takes one serial byte per cycle while in_stall is low, hunts for the 0xB5
// 0x62 sync pair, checks class, id and little-endian length against cfg
// registers, forwards each payload byte with its index and reports a good or
// bad Fletcher checksum at CK_B. Each byte is parsed in the cycle it is
// accepted (in_valid high, in_stall low); its result, if any, is registered
// in the output buffer's result register, or in its skid entry while that
// register holds an untaken result. in_stall rises only when both entries
// hold untaken results. Write cfg only while the block is idle.
module ubx_frame_receiver_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   in_rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_kind,
  output logic [15:0]                       out_byte_index,
  output logic [7:0]                        out_payload_byte,
  input  wire logic                         cfg_we,
  input  wire logic [ubx_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [ubx_pkg::CfgDataW-1:0] cfg_data
);

  ubx_pkg::cfg_t cfg;
  ubx_pkg::result_req_t res;
  logic accept;
  logic full;

  assign in_stall = full;
  assign accept = in_valid && !full;

  ubx_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ubx_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .cfg     (cfg),
    .res     (res)
  );

  ubx_out_buf u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (res),
    .full             (full),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte)
  );

`ifndef SYNTHESIS
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != ubx_pkg::KIND_PAYLOAD) |->
      (out_byte_index == 16'd0 && out_payload_byte == 8'd0))
    else $error("checksum report carries payload fields");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == ubx_pkg::KIND_PAYLOAD || out_kind == ubx_pkg::KIND_GOOD ||
                   out_kind == ubx_pkg::KIND_BAD))
    else $error("illegal result kind");

  a_full_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && !out_stall) |=> !in_stall)
    else $error("skid entry not released after drain");
`endif

endmodule
`default_nettype wire

FILE: tb/ubx_frame_receiver_top_test.sv
// Self-checking testbench for the UBX frame receiver with a built-in frame parser predictor.
`timescale 1ns / 1ps
module ubx_frame_receiver_top_test;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned LongHold = 60;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PhaseBytes = 200;
  localparam int unsigned RandomPhases = 7;
  localparam int unsigned ReportMax = 10;
  localparam logic [ubx_pkg::CfgIdxW-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] idx;
    logic [7:0]  data;
  } frame_out_t;

  typedef logic [7:0] byte_q_t[$];

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [7:0]                   in_rx_byte = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [1:0]                   out_kind;
  logic [15:0]                  out_byte_index;
  logic [7:0]                   out_payload_byte;
  logic                         cfg_we = 1'b0;
  logic [ubx_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [ubx_pkg::CfgDataW-1:0] cfg_data = '0;

  // parser copy
  logic [7:0]      want_class = ubx_pkg::CLASS_RST;
  logic [7:0]      want_id = ubx_pkg::ID_RST;
  logic [15:0]     want_length = ubx_pkg::LENGTH_RST;
  ubx_pkg::phase_t parse_ph = ubx_pkg::PH_HUNT;
  logic [15:0]     pay_count = '0;
  logic [7:0]      len_lo_seen = '0;
  logic [7:0]      sum_a = '0;
  logic [7:0]      sum_b = '0;
  logic [7:0]      rx_sum_a = '0;
  frame_out_t      pending_outputs[$];
  frame_out_t      head_out;

  bit          quiet = 1'b0;
  bit          long_hold = 1'b0;
  bit          stall_seen = 1'b0;
  int unsigned stall_len;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned framed_bytes = 0;
  int unsigned cfg_writes = 0;
  int unsigned n_payload = 0;
  int unsigned n_good = 0;
  int unsigned n_bad = 0;

  ubx_frame_receiver_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void fold_sum(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  function automatic ubx_pkg::phase_t resync_phase(input logic [7:0] b);
    if (b == ubx_pkg::SYNC_FIRST) return ubx_pkg::PH_SYNC2;
    return ubx_pkg::PH_HUNT;
  endfunction

  function automatic void predict_frame_output(input logic [7:0] b);
    case (parse_ph)
      ubx_pkg::PH_SYNC2: begin
        if (b == ubx_pkg::SYNC_SECOND) begin
          sum_a = '0;
          sum_b = '0;
          pay_count = '0;
          parse_ph = ubx_pkg::PH_CLASS;
        end else if (b != ubx_pkg::SYNC_FIRST) begin
          parse_ph = ubx_pkg::PH_HUNT;
        end
      end
      ubx_pkg::PH_CLASS: begin
        if (b == want_class) begin
          fold_sum(b);
          parse_ph = ubx_pkg::PH_ID;
        end else begin
          parse_ph = resync_phase(b);
        end
      end
      ubx_pkg::PH_ID: begin
        if (b == want_id) begin
          fold_sum(b);
          parse_ph = ubx_pkg::PH_LENLO;
        end else begin
          parse_ph = resync_phase(b);
        end
      end
      ubx_pkg::PH_LENLO: begin
        if (b == want_length[7:0]) begin
          fold_sum(b);
          len_lo_seen = b;
          parse_ph = ubx_pkg::PH_LENHI;
        end else begin
          parse_ph = resync_phase(b);
        end
      end
      ubx_pkg::PH_LENHI: begin
        if ({b, len_lo_seen} == want_length) begin
          fold_sum(b);
          pay_count = '0;
          parse_ph = (want_length == 16'd0) ? ubx_pkg::PH_CKA : ubx_pkg::PH_PAYLOAD;
        end else begin
          parse_ph = resync_phase(b);
        end
      end
      ubx_pkg::PH_PAYLOAD: begin
        fold_sum(b);
        pending_outputs.push_back('{kind: ubx_pkg::KIND_PAYLOAD, idx: pay_count, data: b});
        pay_count = pay_count + 16'd1;
        if (pay_count >= want_length || pay_count == 16'd0) parse_ph = ubx_pkg::PH_CKA;
      end
      ubx_pkg::PH_CKA: begin
        rx_sum_a = b;
        parse_ph = ubx_pkg::PH_CKB;
      end
      ubx_pkg::PH_CKB: begin
        parse_ph = ubx_pkg::PH_HUNT;
        if (rx_sum_a == sum_a && b == sum_b) begin
          pending_outputs.push_back('{kind: ubx_pkg::KIND_GOOD, idx: 16'd0, data: 8'd0});
        end else begin
          pending_outputs.push_back('{kind: ubx_pkg::KIND_BAD, idx: 16'd0, data: 8'd0});
        end
      end
      default: parse_ph = resync_phase(b);
    endcase
  endfunction

  function automatic logic [15:0] fletcher8(input byte_q_t q, input int first);
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    ck_a = '0;
    ck_b = '0;
    for (int i = first; i < q.size(); i++) begin
      ck_a = ck_a + q[i];
      ck_b = ck_b + ck_a;
    end
    return {ck_a, ck_b};
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) begin
      stall_seen = 1'b1;
      @(posedge clk);
    end
    predict_frame_output(b);
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) push_byte(q[i]);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [ubx_pkg::CfgIdxW-1:0] idx,
                           input logic [ubx_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ubx_pkg::CFG_CLASS: want_class = data[7:0];
      ubx_pkg::CFG_ID: want_id = data[7:0];
      ubx_pkg::CFG_LENGTH: want_length = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // corrupt byte wrong_at and/or cut the frame to stop_at bytes; -1 leaves it whole
  task automatic send_frame(input int wrong_at, input int stop_at, input bit bad_ck);
    byte_q_t     frame;
    logic [15:0] ck;
    logic [7:0]  w;
    frame.push_back(ubx_pkg::SYNC_FIRST);
    frame.push_back(ubx_pkg::SYNC_SECOND);
    frame.push_back(want_class);
    frame.push_back(want_id);
    frame.push_back(want_length[7:0]);
    frame.push_back(want_length[15:8]);
    for (int i = 0; i < int'(want_length); i++) frame.push_back(8'($urandom));
    ck = fletcher8(frame, 2);
    if (bad_ck) begin
      if ($urandom_range(0, 3) == 0) begin
        ck = {ubx_pkg::SYNC_FIRST, ubx_pkg::SYNC_FIRST};
      end else begin
        ck = ck ^ (16'd1 << $urandom_range(0, 15));
      end
    end
    frame.push_back(ck[15:8]);
    frame.push_back(ck[7:0]);
    if (wrong_at >= 0) begin
      w = ($urandom_range(0, 1) != 0) ? ubx_pkg::SYNC_FIRST : 8'($urandom);
      if (w == frame[wrong_at]) w = ~w;
      frame[wrong_at] = w;
    end
    if (stop_at >= 0) begin
      while (frame.size() > stop_at) void'(frame.pop_back());
    end
    framed_bytes += frame.size();
    send_bytes(frame);
  endtask

  function automatic logic [7:0] pick_header_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_frame(-1, -1, 1'b0);
    send_frame(-1, -1, 1'b1);
  endtask

  task automatic test_sync_and_zero_length();
    byte_q_t q;
    wait_idle();
    write_cfg(ubx_pkg::CFG_CLASS, 16'h0000);
    write_cfg(ubx_pkg::CFG_ID, 16'h00FF);
    write_cfg(ubx_pkg::CFG_LENGTH, 16'h0000);
    write_cfg(CFG_SPARE, 16'($urandom));
    // repeated first sync, then a good empty frame
    q = '{8'hB5, 8'hB5, 8'h62, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFD};
    send_bytes(q);
    // bad empty frame whose check bytes look like sync
    q = '{8'hB5, 8'h62, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hB5, 8'hB5};
    send_bytes(q);
  endtask

  task automatic test_resync_and_length_change();
    byte_q_t     q;
    logic [15:0] ck;
    wait_idle();
    write_cfg(ubx_pkg::CFG_CLASS, 16'h00FF);
    write_cfg(ubx_pkg::CFG_ID, 16'h0000);
    write_cfg(ubx_pkg::CFG_LENGTH, 16'hFFFF);
    // id mismatch on a sync byte restarts the frame
    q = '{8'hB5, 8'h62, 8'hFF, 8'hB5, 8'h62, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF};
    send_bytes(q);
    wait_idle();
    // shrink the length under an open payload
    write_cfg(ubx_pkg::CFG_LENGTH, 16'd2);
    q = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h5A};
    ck = fletcher8(q, 0);
    q = '{8'h5A, ck[15:8], ck[7:0]};
    send_bytes(q);
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_cfg(ubx_pkg::CFG_LENGTH, 16'd40);
    long_hold = 1'b1;
    send_frame(-1, -1, 1'b0);
    send_frame(-1, -1, 1'b1);
  endtask

  task automatic test_random_traffic();
    byte_q_t     noise;
    int unsigned start;
    int unsigned pick;
    int unsigned pos;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      wait_idle();
      write_cfg(ubx_pkg::CFG_CLASS, {8'h00, pick_header_byte()});
      write_cfg(ubx_pkg::CFG_ID, {8'h00, pick_header_byte()});
      write_cfg(ubx_pkg::CFG_LENGTH, ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 2))
                                                                 : 16'($urandom_range(3, 20)));
      quiet = (ph == RandomPhases - 1);
      start = framed_bytes;
      while (framed_bytes - start < PhaseBytes) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_frame(-1, -1, 1'b0);
        end else if (pick < 70) begin
          send_frame(-1, -1, 1'b1);
        end else if (pick < 82) begin
          pos = $urandom_range(1, 5);
          send_frame(pos, pos + 1, 1'b0);
        end else if (pick < 92) begin
          send_frame(-1, $urandom_range(2, 6 + int'(want_length)), 1'b0);
        end else begin
          noise.delete();
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
              0: noise.push_back(ubx_pkg::SYNC_FIRST);
              1: noise.push_back(ubx_pkg::SYNC_SECOND);
              default: noise.push_back(8'($urandom));
            endcase
          end
          send_bytes(noise);
        end
      end
    end
  endtask

  always begin
    @(negedge clk);
    if (long_hold) begin
      out_stall <= 1'b1;
      repeat (LongHold) @(negedge clk);
      out_stall <= 1'b0;
      long_hold = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_len = $urandom_range(1, 17);
      out_stall <= 1'b1;
      repeat (stall_len) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        errors++;
        if (errors <= ReportMax)
          $display("[%0t] output with none pending: kind %0d idx %0d byte %02h",
                   $realtime, out_kind, out_byte_index, out_payload_byte);
      end else begin
        head_out = pending_outputs.pop_front();
        if (out_kind !== head_out.kind || out_byte_index !== head_out.idx ||
            out_payload_byte !== head_out.data) begin
          errors++;
          if (errors <= ReportMax)
            $display("[%0t] mismatch: expected kind %0d idx %0d byte %02h, got %0d %0d %02h",
                     $realtime, head_out.kind, head_out.idx, head_out.data,
                     out_kind, out_byte_index, out_payload_byte);
        end
        case (head_out.kind)
          ubx_pkg::KIND_PAYLOAD: n_payload++;
          ubx_pkg::KIND_GOOD: n_good++;
          default: n_bad++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("ubx_frame_receiver_top_test: errors");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_sync_and_zero_length();
    test_resync_and_length_change();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    $display("framed bytes %0d, config writes %0d: %0d payload bytes, %0d good / %0d bad frames",
             framed_bytes, cfg_writes, n_payload, n_good, n_bad);
    $display("input stall %s, %0d mismatches", stall_seen ? "reached" : "not reached", errors);
    if (errors == 0 && pending_outputs.size() == 0) begin
      $display("ubx_frame_receiver_top_test: clean");
    end else begin
      $display("ubx_frame_receiver_top_test: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ubx_pkg.sv
hdl/ubx_cfg_regs.sv
hdl/ubx_parser.sv
hdl/ubx_out_buf.sv
hdl/ubx_frame_receiver_top.sv
tb/ubx_frame_receiver_top_test.sv
